// ===== hdl/bst_pkg.sv =====
package bst_pkg;

	localparam int POS_BITS = 16;
	localparam int MAX_WORD_LEN = 511;
	localparam int LEN_BITS = $clog2(MAX_WORD_LEN + 1);

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_WORD = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_LT = 3'd3;
	localparam logic [2:0] MODE_HALT = 3'd4;

	localparam logic [2:0] RM_NONE = 3'd0;
	localparam logic [2:0] RM_UNDER = 3'd1;
	localparam logic [2:0] RM_N = 3'd2;
	localparam logic [2:0] RM_NI = 3'd3;
	localparam logic [2:0] RM_NIL = 3'd4;

	localparam logic [2:0] KIND_EOF = 3'd0;
	localparam logic [2:0] KIND_PLACEHOLDER = 3'd1;
	localparam logic [2:0] KIND_NIL = 3'd2;
	localparam logic [2:0] KIND_SYMBOL = 3'd3;
	localparam logic [2:0] KIND_INTEGER = 3'd4;
	localparam logic [2:0] KIND_ARROW = 3'd5;
	localparam logic [2:0] KIND_PUNCT = 3'd6;
	localparam logic [2:0] KIND_ERROR = 3'd7;

	localparam logic [30:0] INT_LIMIT = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [7:0]  char_code;
		logic [30:0] int_value;
		logic        int_overflow;
		logic [15:0] word_start;
		logic [8:0]  word_length;
		logic        last_of_run;
	} tok_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_t       first;
		tok_t       second;
	} pair_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_wordch(input logic [7:0] c);
		return is_letter(c) || is_digit(c) || c == "_";
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c == "[" || c == "]" || c == "(" || c == ")" || c == ":" || c == ","
			|| c == ";" || c == "." || c == "+" || c == "-" || c == "*" || c == "/";
	endfunction

endpackage

// ===== hdl/bst_if.sv =====
interface bst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       is_end;

	modport source(output valid, output byte_in, output is_end, input ready);
	modport sink(input valid, input byte_in, input is_end, output ready);
endinterface

interface bst_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [7:0]  char_code;
	logic [30:0] int_value;
	logic        int_overflow;
	logic [15:0] word_start;
	logic [8:0]  word_length;
	logic        last_of_run;

	modport source(output valid, output token_kind, output char_code, output int_value,
		output int_overflow, output word_start, output word_length, output last_of_run,
		input ready);
	modport sink(input valid, input token_kind, input char_code, input int_value,
		input int_overflow, input word_start, input word_length, input last_of_run,
		output ready);
endinterface

// ===== hdl/bst_lex.sv =====
module bst_lex (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     byte_in,
	input  logic           is_end,
	output bst_pkg::pair_t pair_o
);
	import bst_pkg::*;

	logic [2:0]          mode_q, mode_n;
	logic [2:0]          rm_q, rm_n;
	logic [30:0]         acc_q, acc_n;
	logic                ovf_q, ovf_n;
	logic [POS_BITS-1:0] start_q, start_n;
	logic [LEN_BITS-1:0] len_q, len_n;
	logic [POS_BITS-1:0] pos_q, pos_n;
	logic                end_w;

	always_comb begin
		logic [7:0]          c;
		logic                fl_v;
		tok_t                fl_tok;
		logic                st_v;
		tok_t                st_tok;
		logic [2:0]          st_mode;
		logic [2:0]          st_rm;
		logic [30:0]         st_acc;
		logic                st_ovf;
		logic [POS_BITS-1:0] st_start;
		logic [LEN_BITS-1:0] st_len;
		logic                a_v;
		logic                b_v;
		tok_t                a_tok;
		tok_t                b_tok;
		logic [34:0]         prod;
		logic                use_st;

		c = byte_in;
		end_w = is_end || c == 8'd0;

		fl_v = 1'b0;
		fl_tok = '0;
		unique case (mode_q)
			MODE_WORD: begin
				fl_v = 1'b1;
				if (rm_q == RM_UNDER) begin
					fl_tok.token_kind = KIND_PLACEHOLDER;
				end else if (rm_q == RM_NIL) begin
					fl_tok.token_kind = KIND_NIL;
				end else begin
					fl_tok.token_kind = KIND_SYMBOL;
					fl_tok.word_start = 16'(start_q);
					fl_tok.word_length = 9'(len_q);
				end
			end
			MODE_NUMBER: begin
				fl_v = 1'b1;
				fl_tok.token_kind = KIND_INTEGER;
				fl_tok.int_value = acc_q;
				fl_tok.int_overflow = ovf_q;
			end
			MODE_LT: begin
				fl_v = 1'b1;
				fl_tok.token_kind = KIND_PUNCT;
				fl_tok.char_code = "<";
			end
			default: begin
				fl_v = 1'b0;
			end
		endcase

		st_v = 1'b0;
		st_tok = '0;
		st_mode = MODE_IDLE;
		st_rm = rm_q;
		st_acc = acc_q;
		st_ovf = ovf_q;
		st_start = start_q;
		st_len = len_q;
		priority if (is_space(c)) begin
			st_mode = MODE_IDLE;
		end else if (is_letter(c) || c == "_") begin
			st_mode = MODE_WORD;
			st_start = pos_q;
			st_len = LEN_BITS'(1);
			st_rm = (c == "_") ? RM_UNDER : (c == "n") ? RM_N : RM_NONE;
		end else if (is_digit(c)) begin
			st_mode = MODE_NUMBER;
			st_acc = 31'(c[3:0]);
			st_ovf = 1'b0;
		end else if (is_punct(c)) begin
			st_v = 1'b1;
			st_tok.token_kind = KIND_PUNCT;
			st_tok.char_code = c;
		end else if (c == "<") begin
			st_mode = MODE_LT;
		end else begin
			st_v = 1'b1;
			st_tok.token_kind = KIND_ERROR;
			st_tok.char_code = c;
			st_mode = MODE_HALT;
		end

		prod = 35'(acc_q) * 35'd10 + 35'(c[3:0]);

		a_v = 1'b0;
		b_v = 1'b0;
		a_tok = fl_tok;
		b_tok = st_tok;
		use_st = 1'b0;
		mode_n = mode_q;
		rm_n = rm_q;
		acc_n = acc_q;
		ovf_n = ovf_q;
		start_n = start_q;
		len_n = len_q;
		pos_n = pos_q;

		if (end_w) begin
			a_v = fl_v;
			b_v = 1'b1;
			b_tok = '0;
			b_tok.token_kind = KIND_EOF;
			mode_n = MODE_IDLE;
			rm_n = RM_NONE;
			acc_n = '0;
			ovf_n = 1'b0;
			start_n = '0;
			len_n = '0;
			pos_n = '0;
		end else begin
			pos_n = pos_q + POS_BITS'(1);
			unique case (mode_q)
				MODE_HALT: begin
					mode_n = MODE_HALT;
				end
				MODE_WORD: begin
					if (is_wordch(c)) begin
						if (rm_q == RM_N && c == "i") begin
							rm_n = RM_NI;
						end else if (rm_q == RM_NI && c == "l") begin
							rm_n = RM_NIL;
						end else begin
							rm_n = RM_NONE;
						end
						if (len_q < LEN_BITS'(MAX_WORD_LEN)) begin
							len_n = len_q + LEN_BITS'(1);
						end
					end else begin
						a_v = 1'b1;
						use_st = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						if (prod > 35'(INT_LIMIT)) begin
							acc_n = INT_LIMIT;
							ovf_n = 1'b1;
						end else begin
							acc_n = prod[30:0];
						end
					end else begin
						a_v = 1'b1;
						use_st = 1'b1;
					end
				end
				MODE_LT: begin
					if (c == "-") begin
						b_v = 1'b1;
						b_tok = '0;
						b_tok.token_kind = KIND_ARROW;
						mode_n = MODE_IDLE;
					end else begin
						a_v = 1'b1;
						use_st = 1'b1;
					end
				end
				default: begin
					use_st = 1'b1;
				end
			endcase
			if (use_st) begin
				b_v = st_v;
				mode_n = st_mode;
				rm_n = st_rm;
				acc_n = st_acc;
				ovf_n = st_ovf;
				start_n = st_start;
				len_n = st_len;
			end
		end

		pair_o = '0;
		if (a_v) begin
			pair_o.first = a_tok;
			pair_o.second = b_tok;
			pair_o.cnt = b_v ? 2'd2 : 2'd1;
		end else begin
			pair_o.first = b_tok;
			pair_o.cnt = b_v ? 2'd1 : 2'd0;
		end
		if (pair_o.cnt == 2'd2) begin
			pair_o.second.last_of_run = 1'b1;
		end else begin
			pair_o.first.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			rm_q <= RM_NONE;
			acc_q <= '0;
			ovf_q <= 1'b0;
			start_q <= '0;
			len_q <= '0;
			pos_q <= '0;
		end else if (take) begin
			mode_q <= mode_n;
			rm_q <= rm_n;
			acc_q <= acc_n;
			ovf_q <= ovf_n;
			start_q <= start_n;
			len_q <= len_n;
			pos_q <= pos_n;
		end
	end

`ifndef SYNTHESIS
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode_q == MODE_HALT && !end_w) |-> pair_o.cnt == 2'd0)
		else $error("halted scanner produced a token");
	a_end_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(take && end_w) |-> ((pair_o.cnt == 2'd1 && pair_o.first.token_kind == KIND_EOF)
		|| (pair_o.cnt == 2'd2 && pair_o.second.token_kind == KIND_EOF)))
		else $error("end of source did not close with EOF");
	a_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(take && end_w) |=> (pos_q == '0 && mode_q == MODE_IDLE))
		else $error("scanner state not cleared after end of source");
`endif

endmodule

// ===== hdl/bst_buf.sv =====
module bst_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  bst_pkg::pair_t pair_i,
	output logic           room,
	bst_out_if.source      dst
);
	import bst_pkg::*;

	logic v0_s1;
	logic v1_s1;
	tok_t t0_s1;
	tok_t t1_s1;
	logic out_v_q;
	tok_t out_q;
	logic mv;

	assign mv = v0_s1 && (!out_v_q || dst.ready);
	assign room = !v0_s1 || (mv && !v1_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_s1 <= 1'b0;
			v1_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				v0_s1 <= pair_i.cnt != 2'd0;
				v1_s1 <= pair_i.cnt == 2'd2;
			end else if (mv) begin
				v0_s1 <= v1_s1;
				v1_s1 <= 1'b0;
			end
			if (mv) begin
				out_v_q <= 1'b1;
			end else if (dst.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			t0_s1 <= pair_i.first;
			t1_s1 <= pair_i.second;
		end else if (mv) begin
			t0_s1 <= t1_s1;
		end
		if (mv) begin
			out_q <= t0_s1;
		end
	end

	assign dst.valid = out_v_q;
	assign dst.token_kind = out_q.token_kind;
	assign dst.char_code = out_q.char_code;
	assign dst.int_value = out_q.int_value;
	assign dst.int_overflow = out_q.int_overflow;
	assign dst.word_start = out_q.word_start;
	assign dst.word_length = out_q.word_length;
	assign dst.last_of_run = out_q.last_of_run;

`ifndef SYNTHESIS
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 |-> v0_s1)
		else $error("second slot holds a word while the first is empty");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v0_s1 && !mv) |-> !load)
		else $error("pending words overwritten");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !dst.ready) |=> (out_v_q && $stable(out_q)))
		else $error("output word changed while stalled");
`endif

endmodule

// ===== hdl/byte_stream_tokenizer.sv =====
// Channel  Role     Words carried
// src      sink     byte_in, is_end (a zero byte also ends the source)
// dst      source   token_kind, char_code, int_value, int_overflow, word_start,
//                   word_length, last_of_run
//
// One byte is taken per cycle while the token register has room; each byte
// yields zero, one or two tokens. The output port drains one token per cycle
// while the consumer keeps ready high, so a byte that yields two tokens holds
// off the next byte. A token passes the token register, then the output register.
// A two-slot token register and the output register decouple the two sides.
// Reset clears the scanner state and all valid flags at once.
module byte_stream_tokenizer (
	input  logic      clk,
	input  logic      arst_n,
	bst_in_if.sink    src,
	bst_out_if.source dst
);
	import bst_pkg::*;

	pair_t pair;
	logic  room;
	logic  take;

	assign src.ready = room;
	assign take = src.valid && room;

	bst_lex u_lex (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.byte_in(src.byte_in),
		.is_end (src.is_end),
		.pair_o (pair)
	);

	bst_buf u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.pair_i (pair),
		.room   (room),
		.dst    (dst)
	);

endmodule
